// File: rtl/hocc_pkg.sv
// ----------------------------------------------------------------------------
// hocc_pkg
// shared types, constants and helpers of the hit onset and crossing classifier
// ----------------------------------------------------------------------------
package hocc_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int MAG_W     = 16;
  localparam int RATE_W    = 18;
  localparam int THR_W     = 15;
  localparam int CFG_W     = 18;
  localparam int OUT_IDX_W = 11;

  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(48000);
  localparam logic [RATE_W-1:0] RATE_MIN   = RATE_W'(8000);
  localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(3);

  // onset threshold: magnitude times this reaches the peak (one percent)
  localparam int ONSET_SCALE = 100;
  // crossings per second is twice the frequency, so 500 Hz gives 1000
  localparam int FREQ_SCALE  = 1000;

  typedef enum logic [0:0] {
    CFG_SAMPLE_RATE = 1'b0,
    CFG_ACT_THR     = 1'b1
  } cfg_idx_t;

  // what one lane reports to the merge stage for the sample in its stage a
  typedef struct packed {
    logic valid;
    logic hit;
  } lane_flags_t;

  // magnitude of a q1.15 sample, -32768 gives 32768
  function automatic logic [MAG_W-1:0] sample_mag(input logic [SAMPLE_W-1:0] s);
    logic [MAG_W-1:0] neg;
    neg = ~s + 1'b1;
    return s[SAMPLE_W-1] ? neg : s;
  endfunction

endpackage

// File: rtl/hocc_ram.sv
// ----------------------------------------------------------------------------
// hocc_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module hocc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/hocc_lane.sv
// ----------------------------------------------------------------------------
// hocc_lane
// one channel lane: magnitude, onset test, energy sum and sign change count
// ----------------------------------------------------------------------------
module hocc_lane #(
  parameter int CNT_W = 12,
  parameter int EN_W  = 44
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        clear,
  input  logic                        rd_valid,
  input  logic [hocc_pkg::SAMPLE_W-1:0] rd_data,
  input  logic [hocc_pkg::MAG_W-1:0]  peak,
  input  logic [hocc_pkg::THR_W-1:0]  threshold,
  input  logic                        go,
  output hocc_pkg::lane_flags_t       flags,
  output logic [EN_W-1:0]             energy,
  output logic [CNT_W-1:0]            crossings
);
  import hocc_pkg::*;

  localparam int SCALED_W = MAG_W + 7;

  logic                 valid_a;
  logic [MAG_W-1:0]     mag_a;
  logic                 neg_a;
  logic                 valid_b;
  logic [2*MAG_W-1:0]   sq_b;
  logic                 have_prev;
  logic                 prev_neg;
  logic [SCALED_W-1:0]  scaled_a;
  logic                 active_a;

  assign scaled_a = SCALED_W'(mag_a) * SCALED_W'(ONSET_SCALE);
  assign flags.valid = valid_a;
  assign flags.hit   = scaled_a >= SCALED_W'(peak);
  assign active_a    = mag_a >= MAG_W'(threshold);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a   <= 1'b0;
      valid_b   <= 1'b0;
      have_prev <= 1'b0;
      prev_neg  <= 1'b0;
      crossings <= '0;
      energy    <= '0;
    end else begin
      valid_a <= rd_valid;
      valid_b <= valid_a && go;
      if (clear) begin
        have_prev <= 1'b0;
        prev_neg  <= 1'b0;
        crossings <= '0;
        energy    <= '0;
      end else begin
        // sign changes among active samples from the onset on
        if (valid_a && go && active_a) begin
          if (have_prev && (neg_a != prev_neg)) begin
            crossings <= crossings + 1'b1;
          end
          prev_neg  <= neg_a;
          have_prev <= 1'b1;
        end
        if (valid_b) begin
          energy <= energy + EN_W'(sq_b);
        end
      end
    end
    mag_a <= sample_mag(rd_data);
    neg_a <= rd_data[SAMPLE_W-1];
    sq_b  <= mag_a * mag_a;
  end

endmodule

// File: rtl/hocc_merge.sv
// ----------------------------------------------------------------------------
// hocc_merge
// combines the two lanes: onset capture, channel pick and window decision
// ----------------------------------------------------------------------------
module hocc_merge #(
  parameter int AW    = 11,
  parameter int CNT_W = 12,
  parameter int EN_W  = 44
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       clear,
  input  hocc_pkg::lane_flags_t      left_flags,
  input  hocc_pkg::lane_flags_t      right_flags,
  input  logic [AW-1:0]              idx_a,
  input  logic                       start,
  input  logic [CNT_W-1:0]           len,
  input  logic [EN_W-1:0]            energy_l,
  input  logic [EN_W-1:0]            energy_r,
  input  logic [CNT_W-1:0]           cross_l,
  input  logic [CNT_W-1:0]           cross_r,
  input  logic [hocc_pkg::RATE_W-1:0] rate,
  output logic                       go,
  output logic                       decided,
  output logic [AW-1:0]              onset,
  output logic                       pick_right,
  output logic [CNT_W-1:0]           changes,
  output logic [CNT_W+hocc_pkg::RATE_W-1:0] lhs,
  output logic [CNT_W+hocc_pkg::RATE_W-1:0] rhs
);
  import hocc_pkg::*;

  localparam int PROD_W = CNT_W + RATE_W;

  logic              found;
  logic              step1;
  logic [CNT_W-1:0]  active_len;
  logic [RATE_W-1:0] rate_eff;
  logic [CNT_W-1:0]  changes_sel;

  // lanes run in lockstep, so the left valid stands for both
  assign go          = found || (left_flags.valid && (left_flags.hit || right_flags.hit));
  assign rate_eff    = (rate < RATE_MIN) ? RATE_MIN : rate;
  assign changes_sel = pick_right ? cross_r : cross_l;

  always_ff @(posedge clk) begin
    if (rst) begin
      found   <= 1'b0;
      step1   <= 1'b0;
      decided <= 1'b0;
    end else begin
      step1 <= start;
      if (clear) begin
        found   <= 1'b0;
        decided <= 1'b0;
      end else begin
        if (left_flags.valid && go && !found) begin
          found <= 1'b1;
        end
        if (step1) begin
          decided <= 1'b1;
        end
      end
    end
    if (left_flags.valid && go && !found) begin
      onset <= idx_a;
    end
    if (start) begin
      pick_right <= energy_r > energy_l;
      active_len <= (len > CNT_W'(onset)) ? (len - CNT_W'(onset)) : CNT_W'(1);
    end
    if (step1) begin
      changes <= changes_sel;
      lhs     <= PROD_W'(changes_sel) * PROD_W'(rate_eff);
      rhs     <= PROD_W'(active_len) * PROD_W'(FREQ_SCALE);
    end
  end

endmodule

// File: rtl/hit_onset_and_crossing_classifier_unit.sv
// ----------------------------------------------------------------------------
// hit_onset_and_crossing_classifier_unit
// stores a stereo drum hit and classifies onset, channel and crossing rate
// ----------------------------------------------------------------------------
// a non-final pair is taken and gives no result; the result of a hit is
//   registered after the scan, drain and decide states that follow its final pair
// throughput: one pair per cycle while loading; after the final pair the
//   input stalls through one pass over the sample ram, the drain and the
//   decision, and while the previous result still waits on the output
// reset: clears the fill count, the peak, the fsm and the output valid;
//   the sample rams are not cleared, only entries of the current hit are read
module hit_onset_and_crossing_classifier_unit #(
  parameter int MAX_SCAN = 2048
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration write port
  input  logic                              cfg_we,
  input  hocc_pkg::cfg_idx_t                cfg_index,
  input  logic [hocc_pkg::CFG_W-1:0]        cfg_data,
  // sample pair input
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [hocc_pkg::SAMPLE_W-1:0] left_sample,
  input  logic signed [hocc_pkg::SAMPLE_W-1:0] right_sample,
  input  logic                              final_pair,
  // classification output
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [hocc_pkg::OUT_IDX_W-1:0]    onset_index,
  output logic                              use_short_window,
  output logic                              analysis_channel,
  output logic [hocc_pkg::OUT_IDX_W-1:0]    crossing_count
);
  import hocc_pkg::*;

  localparam int AW     = $clog2(MAX_SCAN);
  localparam int CNT_W  = $clog2(MAX_SCAN + 1);
  localparam int EN_W   = 2 * MAG_W + CNT_W;
  localparam int PROD_W = CNT_W + RATE_W;
  localparam logic [CNT_W-1:0] SCAN_DEPTH = CNT_W'(MAX_SCAN);
  // drain count value at which both energy sums are final and the merge starts
  localparam logic [1:0] DRAIN_LAST = 2'd3;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  cnt;          // pairs stored in the current hit
  logic [MAG_W-1:0]  peak;         // running peak of both channels
  logic [CNT_W-1:0]  len;          // scan length latched on the final pair
  logic [CNT_W-1:0]  scan_idx;
  logic [1:0]        drain_cnt;
  logic [RATE_W-1:0] rate;
  logic [THR_W-1:0]  threshold;
  logic              rd_valid;     // ram read data valid
  logic [AW-1:0]     idx1;
  logic [AW-1:0]     idx_a;

  logic              accept;
  logic              store_ok;
  logic              wr_en;
  logic              rd_en;
  logic              clear;
  logic              start;
  logic              out_free;
  logic              emit;
  logic [MAG_W-1:0]  mag_l;
  logic [MAG_W-1:0]  mag_r;
  logic [MAG_W-1:0]  peak_next;
  logic [SAMPLE_W-1:0] rd_left;
  logic [SAMPLE_W-1:0] rd_right;

  lane_flags_t       flags_l;
  lane_flags_t       flags_r;
  logic [EN_W-1:0]   energy_l;
  logic [EN_W-1:0]   energy_r;
  logic [CNT_W-1:0]  cross_l;
  logic [CNT_W-1:0]  cross_r;
  logic              go;
  logic              decided;
  logic [AW-1:0]     onset;
  logic              pick_right;
  logic [CNT_W-1:0]  changes;
  logic [PROD_W-1:0] lhs;
  logic [PROD_W-1:0] rhs;

  // input is only taken while loading; a pending result does not block it
  assign in_stall = (state != ST_LOAD);
  assign accept   = in_valid && !in_stall;
  // pairs past capacity are dropped but a dropped final pair still counts
  assign store_ok = cnt < SCAN_DEPTH;
  assign wr_en    = accept && store_ok;
  assign rd_en    = (state == ST_SCAN);
  assign clear    = accept && final_pair;
  assign start    = (state == ST_DRAIN) && (drain_cnt == DRAIN_LAST);
  assign out_free = !out_valid || !out_stall;
  // result of the current hit moves into the output register
  assign emit     = (state == ST_DECIDE) && decided && out_free;

  assign mag_l = sample_mag(left_sample);
  assign mag_r = sample_mag(right_sample);

  always_comb begin
    peak_next = peak;
    if (mag_l > peak_next) begin
      peak_next = mag_l;
    end
    if (mag_r > peak_next) begin
      peak_next = mag_r;
    end
  end

  // sample stores, written while loading, read once per scan
  hocc_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_SCAN)) u_left_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cnt[AW-1:0]),
    .wr_data (left_sample),
    .rd_en   (rd_en),
    .rd_addr (scan_idx[AW-1:0]),
    .rd_data (rd_left)
  );

  hocc_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_SCAN)) u_right_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cnt[AW-1:0]),
    .wr_data (right_sample),
    .rd_en   (rd_en),
    .rd_addr (scan_idx[AW-1:0]),
    .rd_data (rd_right)
  );

  // one lane per channel, both see the merged onset flag
  hocc_lane #(.CNT_W(CNT_W), .EN_W(EN_W)) u_lane_left (
    .clk       (clk),
    .rst       (rst),
    .clear     (clear),
    .rd_valid  (rd_valid),
    .rd_data   (rd_left),
    .peak      (peak),
    .threshold (threshold),
    .go        (go),
    .flags     (flags_l),
    .energy    (energy_l),
    .crossings (cross_l)
  );

  hocc_lane #(.CNT_W(CNT_W), .EN_W(EN_W)) u_lane_right (
    .clk       (clk),
    .rst       (rst),
    .clear     (clear),
    .rd_valid  (rd_valid),
    .rd_data   (rd_right),
    .peak      (peak),
    .threshold (threshold),
    .go        (go),
    .flags     (flags_r),
    .energy    (energy_r),
    .crossings (cross_r)
  );

  hocc_merge #(.AW(AW), .CNT_W(CNT_W), .EN_W(EN_W)) u_merge (
    .clk         (clk),
    .rst         (rst),
    .clear       (clear),
    .left_flags  (flags_l),
    .right_flags (flags_r),
    .idx_a       (idx_a),
    .start       (start),
    .len         (len),
    .energy_l    (energy_l),
    .energy_r    (energy_r),
    .cross_l     (cross_l),
    .cross_r     (cross_r),
    .rate        (rate),
    .go          (go),
    .decided     (decided),
    .onset       (onset),
    .pick_right  (pick_right),
    .changes     (changes),
    .lhs         (lhs),
    .rhs         (rhs)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      cnt       <= '0;
      peak      <= '0;
      scan_idx  <= '0;
      drain_cnt <= '0;
      rate      <= RATE_RESET;
      threshold <= THR_RESET;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // register writes; the user must issue them only while the block is idle, the block does not enforce it
      if (cfg_we) begin
        case (cfg_index)
          CFG_SAMPLE_RATE: rate      <= cfg_data[RATE_W-1:0];
          CFG_ACT_THR:     threshold <= cfg_data[THR_W-1:0];
          default: ;
        endcase
      end

      rd_valid <= rd_en;

      // result register: filled from the merge stage, emptied downstream
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_LOAD: begin
          if (accept) begin
            if (store_ok) begin
              cnt  <= cnt + 1'b1;
              peak <= peak_next;
            end
            if (final_pair) begin
              scan_idx <= '0;
              state    <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          // one address per cycle over the stored hit
          scan_idx <= scan_idx + 1'b1;
          if (scan_idx == len - 1'b1) begin
            drain_cnt <= '0;
            state     <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          // let the ram and lane stages empty before the merge reads sums
          if (drain_cnt == DRAIN_LAST) begin
            state <= ST_DECIDE;
          end else begin
            drain_cnt <= drain_cnt + 1'b1;
          end
        end
        ST_DECIDE: begin
          if (emit) begin
            cnt   <= '0;
            peak  <= '0;
            state <= ST_LOAD;
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end

    // payload registers
    if (clear) begin
      len <= store_ok ? (cnt + 1'b1) : cnt;
    end
    idx1  <= scan_idx[AW-1:0];
    idx_a <= idx1;
    if (emit) begin
      onset_index      <= OUT_IDX_W'(onset);
      use_short_window <= lhs >= rhs;
      analysis_channel <= pick_right;
      crossing_count   <= OUT_IDX_W'(changes);
    end
  end

endmodule

// File: rtl/hocc_checker.sv
// ----------------------------------------------------------------------------
// hocc_checker
// port level checks of the classifier, bound to the top level
// ----------------------------------------------------------------------------
module hocc_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           final_pair,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [hocc_pkg::OUT_IDX_W-1:0] onset_index,
  input logic                           use_short_window,
  input logic                           analysis_channel,
  input logic [hocc_pkg::OUT_IDX_W-1:0] crossing_count
);

  // a final pair starts the scan, so input stalls in the next cycle
  a_final_stalls: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && final_pair |=> in_stall)
    else $error("input not stalled after final pair");

  // a new result only comes out of the analysis phase
  a_result_after_scan: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $rose(out_valid) |-> $past(in_stall))
    else $error("result raised without analysis");

  // leaving analysis always leaves a result on the output
  a_resume_with_result: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $fell(in_stall) |-> out_valid)
    else $error("input resumed without a result");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(onset_index) &&
      $stable(use_short_window) && $stable(analysis_channel) &&
      $stable(crossing_count))
    else $error("stalled result changed");

endmodule

bind hit_onset_and_crossing_classifier_unit hocc_checker u_hocc_checker (.*);

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the drum hit onset and crossing classifier: queued
// sample pairs go through a stalling driver, an in-bench model predicts the
// classification of every hit, and a monitor compares each result field
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hocc_pkg::*;

  localparam int MAX_PAIRS   = 2048;
  localparam int HOLD_CYCLES = 600;
  // quiet cycles before giving up, well above the long hold-off plus one scan
  localparam int QUIET_LIMIT = 12000;

  typedef struct {
    logic signed [SAMPLE_W-1:0] l;
    logic signed [SAMPLE_W-1:0] r;
    logic                       fin;
  } pair_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] onset;
    logic                 short_win;
    logic                 channel;
    logic [OUT_IDX_W-1:0] xings;
  } verdict_t;

  // dut ports, the inputs all known from time zero
  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_we = 1'b0;
  cfg_idx_t                   cfg_index = CFG_SAMPLE_RATE;
  logic [CFG_W-1:0]           cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] left_sample = '0;
  logic signed [SAMPLE_W-1:0] right_sample = '0;
  logic                       final_pair = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [OUT_IDX_W-1:0]       onset_index;
  logic                       use_short_window;
  logic                       analysis_channel;
  logic [OUT_IDX_W-1:0]       crossing_count;

  // stimulus and expectation stores
  pair_t    pair_q[$];
  verdict_t verdict_q[$];
  int       mismatches = 0;

  // idle behavior, changed by the sequencer between phases
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;

  // model state: sample stores, fill count, running peak, registers
  logic signed [SAMPLE_W-1:0] left_mem [MAX_PAIRS];
  logic signed [SAMPLE_W-1:0] right_mem [MAX_PAIRS];
  int unsigned                fill_cnt = 0;
  int unsigned                peak_level = 0;
  logic [RATE_W-1:0]          rate_reg = RATE_RESET;
  logic [THR_W-1:0]           thr_reg = THR_RESET;

  hit_onset_and_crossing_classifier_unit #(
    .MAX_SCAN(MAX_PAIRS)
  ) i_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .left_sample     (left_sample),
    .right_sample    (right_sample),
    .final_pair      (final_pair),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .onset_index     (onset_index),
    .use_short_window(use_short_window),
    .analysis_channel(analysis_channel),
    .crossing_count  (crossing_count)
  );

  initial forever #6 clk = ~clk;

  // magnitude of a q1.15 sample, full negative scale gives 32768
  function automatic int unsigned magnitude(logic signed [SAMPLE_W-1:0] s);
    int v;
    v = s;
    return (v < 0) ? -v : v;
  endfunction

  // store one pair and, on the last pair of a hit, classify the whole hit
  task automatic absorb_pair(input logic signed [SAMPLE_W-1:0] l,
                             input logic signed [SAMPLE_W-1:0] r,
                             input logic fin);
    int unsigned       onset, changes, cur_rate, span, xi, m;
    longint unsigned   e_left, e_right, sq;
    logic              pick_r, seen, prev_pos, now_pos;
    logic signed [SAMPLE_W-1:0] v;
    verdict_t          res;
    // pairs past capacity are dropped but a dropped final still classifies
    if (fill_cnt < MAX_PAIRS) begin
      left_mem[fill_cnt]  = l;
      right_mem[fill_cnt] = r;
      fill_cnt++;
      if (magnitude(l) > peak_level) peak_level = magnitude(l);
      if (magnitude(r) > peak_level) peak_level = magnitude(r);
    end
    if (!fin) return;

    // onset: first index at or above one percent of the peak, 0 for a silent hit
    onset = 0;
    if (peak_level != 0) begin
      for (xi = 0; xi < fill_cnt; xi++) begin
        if (magnitude(left_mem[xi]) * 100 >= peak_level ||
            magnitude(right_mem[xi]) * 100 >= peak_level) begin
          onset = xi;
          break;
        end
      end
    end

    // energy from the onset on, right wins only when strictly larger
    e_left  = 0;
    e_right = 0;
    for (xi = onset; xi < fill_cnt; xi++) begin
      sq = magnitude(left_mem[xi]);
      e_left += sq * sq;
      sq = magnitude(right_mem[xi]);
      e_right += sq * sq;
    end
    pick_r = (e_right > e_left);

    // sign changes among samples at or above the threshold, zero is positive
    changes  = 0;
    seen     = 1'b0;
    prev_pos = 1'b1;
    for (xi = onset; xi < fill_cnt; xi++) begin
      v = pick_r ? right_mem[xi] : left_mem[xi];
      m = magnitude(v);
      if (m < thr_reg) continue;
      now_pos = (v >= 0);
      if (seen && now_pos != prev_pos) changes++;
      prev_pos = now_pos;
      seen     = 1'b1;
    end

    cur_rate = (rate_reg < 8000) ? 8000 : rate_reg;
    span     = (fill_cnt > onset) ? fill_cnt - onset : 1;

    res.onset     = onset[OUT_IDX_W-1:0];
    res.short_win = (longint'(changes) * cur_rate >= longint'(1000) * span);
    res.channel   = pick_r;
    res.xings     = changes[OUT_IDX_W-1:0];
    verdict_q.push_back(res);

    fill_cnt   = 0;
    peak_level = 0;
  endtask

  function automatic void flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %0d at %0t: %s expected %0d got %0d", mismatches, $realtime, what,
               want, got);
  endfunction

  task automatic check_verdict();
    verdict_t want;
    if (verdict_q.size() == 0) begin
      flag_mismatch("result with nothing outstanding, onset_index", 0, 32'(onset_index));
      return;
    end
    want = verdict_q.pop_front();
    if (onset_index !== want.onset)
      flag_mismatch("onset_index", 32'(want.onset), 32'(onset_index));
    if (use_short_window !== want.short_win)
      flag_mismatch("use_short_window", 32'(want.short_win), 32'(use_short_window));
    if (analysis_channel !== want.channel)
      flag_mismatch("analysis_channel", 32'(want.channel), 32'(analysis_channel));
    if (crossing_count !== want.xings)
      flag_mismatch("crossing_count", 32'(want.xings), 32'(crossing_count));
  endtask

  // driver: a transaction completes on valid and no stall; the payload holds
  // while stalled and a fresh pair is only picked once the old one is gone
  always @(posedge clk) begin : drive_pairs
    pair_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) absorb_pair(left_sample, right_sample, final_pair);
      if (!in_valid || !in_stall) begin
        if (pair_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pair_q.pop_front();
          in_valid     <= 1'b1;
          left_sample  <= nxt.l;
          right_sample <= nxt.r;
          final_pair   <= nxt.fin;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result transaction, drives random stalls and one
  // long hold-off that lets the block fill up and push back on the sender
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_verdict();
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // watchdog: long stretches with no transaction at all end the run
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(negedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || rst) quiet = 0;
      else quiet++;
    end
    $display("Regression FAIL");
    $finish;
  end

  function automatic void add_pair(int l, int r, logic fin);
    pair_t p;
    p.l   = l[SAMPLE_W-1:0];
    p.r   = r[SAMPLE_W-1:0];
    p.fin = fin;
    pair_q.push_back(p);
  endfunction

  // random magnitude up to amp with the requested sign, clipped to q1.15
  function automatic logic signed [SAMPLE_W-1:0] shaped(logic pos, int unsigned amp);
    int unsigned m;
    m = $urandom_range(amp, 0);
    if (pos) return (m > 32767) ? 16'sd32767 : SAMPLE_W'(m);
    return SAMPLE_W'(-int'(m));
  endfunction

  function automatic int unsigned pick_amp();
    case ($urandom_range(3))
      0: return 32768;
      1: return $urandom_range(200, 0);
      2: return $urandom_range(5000, 0);
      default: return $urandom_range(32768, 0);
    endcase
  endfunction

  // one hit: either raw noise or a square-ish oscillation with random period,
  // optionally led by a quiet stretch so the onset moves off zero
  function automatic void queue_random_hit(int unsigned len);
    int unsigned quiet, amp_l, amp_r, period, k;
    logic        noisy, pos, inv_r;
    pair_t       p;
    noisy  = ($urandom_range(7) == 0);
    quiet  = ($urandom_range(2) == 0) ? $urandom_range(len / 2, 0) : 0;
    amp_l  = pick_amp();
    amp_r  = pick_amp();
    period = $urandom_range(60, 1);
    pos    = 1'($urandom_range(1));
    inv_r  = 1'($urandom_range(1));
    for (k = 0; k < len; k++) begin
      if (k != 0 && (k % period) == 0) pos = ~pos;
      if (noisy) begin
        p.l = SAMPLE_W'($urandom);
        p.r = SAMPLE_W'($urandom);
      end else if (k < quiet) begin
        p.l = shaped(pos, amp_l / 150);
        p.r = shaped(pos ^ inv_r, amp_r / 150);
      end else begin
        p.l = shaped(pos, amp_l);
        p.r = shaped(pos ^ inv_r, amp_r);
      end
      p.fin = (k == len - 1);
      pair_q.push_back(p);
    end
  endfunction

  function automatic void queue_random_hits(int budget);
    int n, len;
    n = 0;
    while (n < budget) begin
      len = ($urandom_range(99) < 85) ? $urandom_range(24, 1) : $urandom_range(150, 25);
      queue_random_hit(len);
      n += len;
    end
  endfunction

  // registers are only written with the block idle, both in one go
  task automatic set_config(logic [CFG_W-1:0] rate_word, logic [CFG_W-1:0] thr_word);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SAMPLE_RATE;
    cfg_data  <= rate_word;
    @(posedge clk);
    cfg_index <= CFG_ACT_THR;
    cfg_data  <= thr_word;
    @(posedge clk);
    cfg_we <= 1'b0;
    rate_reg = rate_word[RATE_W-1:0];
    thr_reg  = thr_word[THR_W-1:0];
    @(negedge clk);
  endtask

  // sender pause: everything sent and every classification back
  task automatic wait_drained();
    do @(negedge clk);
    while (pair_q.size() != 0 || in_valid || verdict_q.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  function automatic void set_idling(int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endfunction

  // sequencer
  initial begin : sequencer
    int k;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed hits at reset settings, sender slow and receiver slower
    set_idling(27, 46);
    add_pair(0, 0, 1);                    // silent hit of one pair
    add_pair(-32768, 32767, 0);           // full scale both ways
    add_pair(32767, -32768, 0);
    add_pair(0, -1, 0);
    add_pair(-1, 0, 1);                   // equal energy keeps left
    add_pair(99, -99, 0);                 // just under one percent
    add_pair(0, 50, 0);
    add_pair(100, 0, 0);                  // exactly one percent: onset here
    add_pair(10000, -3, 0);
    add_pair(-10000, 3, 0);
    add_pair(20, -20, 1);
    add_pair(5, -5, 0);                   // tie again
    add_pair(-5, 5, 1);
    add_pair(1, 1000, 0);                 // right clearly louder
    add_pair(-1, -1000, 0);
    add_pair(1, 1000, 1);
    add_pair(3, 1, 0);                    // magnitudes around the threshold
    add_pair(-2, 1, 0);
    add_pair(-3, 1, 0);
    add_pair(2, 1, 0);
    add_pair(4, 1, 1);
    wait_drained();

    // lowest legal rate, no threshold; short window exactly on the boundary
    set_config(18'd8000, 18'd0);
    for (k = 0; k < 8; k++) add_pair((k < 4) ? 1000 : -1000, 0, k == 7);
    for (k = 0; k < 9; k++) add_pair((k < 5) ? 1000 : -1000, 0, k == 8);
    queue_random_hits(130);
    wait_drained();

    // highest legal rate, threshold word with bits beyond the register set
    set_config(18'd192000, 18'h3FFFF);
    queue_random_hits(130);
    wait_drained();

    // rates below the floor, roles of sender and receiver swapped
    set_idling(46, 27);
    set_config(18'($urandom_range(7999, 0)), 18'($urandom_range(40, 0)));
    queue_random_hits(130);
    wait_drained();

    set_config(18'h3FFFF, 18'($urandom_range(300, 0)));
    queue_random_hits(130);
    wait_drained();

    set_config(18'($urandom_range(192000, 8000)), 18'($urandom_range(2000, 0)));
    queue_random_hits(150);
    wait_drained();

    // no idling; receiver holds off long while the sender keeps going
    set_idling(0, 0);
    set_config(18'(RATE_RESET), 18'(THR_RESET));
    queue_random_hits(150);
    hold_req = 1'b1;
    wait_drained();

    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
